// ===== rtl/dcwg_pkg.sv =====
// Shared types, constants and the sine quadrant builder for the waveform generator.
// Has no dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package dcwg_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned AMP_W    = 8;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned MAG_W    = 15;

  // pi/2 in unsigned Q2.62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef enum logic [1:0] {
    WAVE_SQUARE   = 2'd0,
    WAVE_SINE     = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_RAMP     = 2'd3
  } wave_t;

  typedef struct packed {
    wave_t               wave;
    logic [AMP_W-1:0]    amplitude;
    logic [PERIOD_W-1:0] period;
  } chan_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_WAIT,
    ST_SCALE,
    ST_DONE
  } eng_state_t;

  // (a*b) >> 62; elaboration only
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // round(32767*sin(pi/2 * m / 2^(phase_bits-2))), Taylor series in Q2.62.
  // Only evaluated at elaboration to fill the quadrant ROM.
  function automatic logic [MAG_W-1:0] sine_quadrant(input logic [16:0] m,
                                                     input int unsigned phase_bits);
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] Den;
    logic [63:0] scaled;
    int          n;
    frac = {47'd0, m} << (64 - phase_bits);
    x    = mul_q62(frac, HALF_PI_Q62);
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (n = 1; n <= 16; n++) begin
      Den  = 64'((2 * n) * (2 * n + 1));
      term = mul_q62(term, x2) / Den;
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    scaled = (sum >> 20) * 64'd32767 + (64'd1 << 41);
    return scaled[56:42];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dual_channel_waveform_generator_top.sv =====
// Top level: config registers, tick input handshake, result output register.
// Depends on dcwg_pkg and dcwg_engine.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+------------------------------------
//  in      | in  | in_valid / in_stall  | tick
//  out     | out | out_valid / out_stall| ch1_sample, ch2_sample
//  cfg     | in  | cfg_valid / cfg_ready| cfg_index (0..5), cfg_data
//
// One tick word with tick=1 runs both channels in turn: a square or silent
// channel is written directly, ramp/triangle go through the shared divider,
// sine through the divider and then a scale step; the divider dividend is
// NUM_W = max(SINE_PHASE_BITS+8, 17) bits wide (20 by default).
// in_stall stays high from accept until the output register takes the result.
// A tick=0 word is taken and dropped without starting the engine.
// rst is synchronous: clears indices, config and the output valid.
// A finished result sits in the output register, so a new tick is taken
// while out_stall holds the last one; the engine waits only if both are full.
`default_nettype none

module dual_channel_waveform_generator_top #(
  parameter int unsigned SINE_PHASE_BITS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // tick channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              tick,
  // sample channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [dcwg_pkg::SAMPLE_W-1:0]          ch1_sample,
  output logic [dcwg_pkg::SAMPLE_W-1:0]          ch2_sample,
  // config write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [7:0]                        cfg_data
);

  // register map
  localparam logic [2:0] REG_CH1_WAVE   = 3'd0;
  localparam logic [2:0] REG_CH1_AMP    = 3'd1;
  localparam logic [2:0] REG_CH1_PERIOD = 3'd2;
  localparam logic [2:0] REG_CH2_WAVE   = 3'd3;
  localparam logic [2:0] REG_CH2_AMP    = 3'd4;
  localparam logic [2:0] REG_CH2_PERIOD = 3'd5;

  dcwg_pkg::chan_cfg_t [1:0] cfg;

  logic                          busy;
  logic                          result_valid;
  logic                          result_take;
  logic [dcwg_pkg::SAMPLE_W-1:0] sample0;
  logic [dcwg_pkg::SAMPLE_W-1:0] sample1;

  // writes land any time; the user is to issue them only while the block is idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CH1_WAVE:   cfg[0].wave      <= dcwg_pkg::wave_t'(cfg_data[1:0]);
        REG_CH1_AMP:    cfg[0].amplitude <= cfg_data;
        REG_CH1_PERIOD: cfg[0].period    <= cfg_data;
        REG_CH2_WAVE:   cfg[1].wave      <= dcwg_pkg::wave_t'(cfg_data[1:0]);
        REG_CH2_AMP:    cfg[1].amplitude <= cfg_data;
        REG_CH2_PERIOD: cfg[1].period    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stall is the engine's busy flag, never a function of in_valid
  assign in_stall = busy;

  dcwg_engine #(
    .PHASE_BITS (SINE_PHASE_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tick_go      (in_valid && tick),
    .busy         (busy),
    .result_valid (result_valid),
    .result_take  (result_take),
    .sample0      (sample0),
    .sample1      (sample1)
  );

  // output register: load when empty or being drained this cycle
  assign result_take = result_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_take) begin
      ch1_sample <= sample0;
      ch2_sample <= sample1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcwg_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on dcwg_pkg for the divisor width.
`default_nettype none

module dcwg_divider #(
  parameter int unsigned NUM_W = 20
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [NUM_W-1:0]             num,
  input  wire logic [dcwg_pkg::PERIOD_W-1:0] den,
  output logic                              busy,
  output logic                              done,
  output logic [NUM_W-1:0]                  quot
);

  localparam int unsigned DEN_W = dcwg_pkg::PERIOD_W;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem, work[NUM_W-1]};
    ge     = (rem_sh >= {1'b0, dvs});
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      rem  <= '0;
      dvs  <= den;
    end else if (busy) begin
      work <= {work[NUM_W-2:0], ge};
      rem  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign quot = work;

endmodule

`default_nettype wire

// ===== rtl/dcwg_sine_rom.sv =====
// Quarter-wave sine ROM with registered read, contents built at elaboration.
// Depends on dcwg_pkg::sine_quadrant.
`default_nettype none

module dcwg_sine_rom #(
  parameter int unsigned PHASE_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic [PHASE_BITS-2:0]         addr,
  output logic      [dcwg_pkg::MAG_W-1:0]    data
);

  localparam int unsigned QUARTER = 1 << (PHASE_BITS - 2);

  logic [dcwg_pkg::MAG_W-1:0] rom_words [QUARTER+1];

  for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
    assign rom_words[i] = dcwg_pkg::sine_quadrant(17'(i), PHASE_BITS);
  end

  always_ff @(posedge clk) begin
    data <= rom_words[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/dcwg_engine.sv =====
// Sequencer and datapath: channel indices, per-channel sample math over the
// shared divider and the sine ROM. Depends on dcwg_pkg, dcwg_divider, dcwg_sine_rom.
`default_nettype none

module dcwg_engine #(
  parameter int unsigned PHASE_BITS = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire dcwg_pkg::chan_cfg_t [1:0]            cfg,
  input  wire logic                                 tick_go,
  output logic                                      busy,
  output logic                                      result_valid,
  input  wire logic                                 result_take,
  output logic [dcwg_pkg::SAMPLE_W-1:0]             sample0,
  output logic [dcwg_pkg::SAMPLE_W-1:0]             sample1
);

  localparam int unsigned AMP_W    = dcwg_pkg::AMP_W;
  localparam int unsigned PERIOD_W = dcwg_pkg::PERIOD_W;
  localparam int unsigned SAMPLE_W = dcwg_pkg::SAMPLE_W;
  localparam int unsigned MAG_W    = dcwg_pkg::MAG_W;
  localparam int unsigned TRI_W    = 2 * AMP_W + 1;
  localparam int unsigned SIN_W    = PHASE_BITS + PERIOD_W;
  localparam int unsigned NUM_W    = (SIN_W > TRI_W) ? SIN_W : TRI_W;
  localparam int unsigned ADDR_W   = PHASE_BITS - 1;
  localparam int unsigned QUARTER  = 1 << (PHASE_BITS - 2);
  localparam int unsigned OFFS_W   = MAG_W + 1;
  localparam int unsigned PROD_W   = (AMP_W - 1) + OFFS_W;

  dcwg_pkg::eng_state_t state, state_next;
  logic                 ch, ch_next;
  logic [PERIOD_W-1:0]  ch_index [2];
  logic [SAMPLE_W-1:0]  samples [2];

  dcwg_pkg::chan_cfg_t  cur;
  logic [PERIOD_W-1:0]  k;
  logic [PERIOD_W-1:0]  half;
  logic                 first_half;
  logic [PERIOD_W-1:0]  kk;
  logic [2*AMP_W-1:0]   amp_k;
  logic [PERIOD_W:0]    r0, r1, r2;
  logic [NUM_W-1:0]     num;

  logic                 div_start, div_busy, div_done;
  logic [NUM_W-1:0]     quot;

  logic [1:0]           quad;
  logic [ADDR_W-1:0]    rom_addr;
  logic [MAG_W-1:0]     mag;
  logic [OFFS_W-1:0]    offs;
  logic [PROD_W-1:0]    sine_prod;

  logic                 sample_we;
  logic [SAMPLE_W-1:0]  sample_val;

  // operand selection for the active channel
  always_comb begin
    cur        = cfg[ch];
    k          = ch_index[ch];
    half       = cur.period >> 1;
    first_half = (k <= half);
    kk         = first_half ? k : (cur.period - k);
    amp_k      = cur.amplitude * ((cur.wave == dcwg_pkg::WAVE_TRIANGLE) ? kk : k);
    // (k+1) mod P; k <= P, two trims cover P = 1
    r0 = {1'b0, k} + 1'b1;
    r1 = (r0 >= {1'b0, cur.period}) ? r0 - {1'b0, cur.period} : r0;
    r2 = (r1 >= {1'b0, cur.period}) ? r1 - {1'b0, cur.period} : r1;
    case (cur.wave)
      dcwg_pkg::WAVE_SINE:     num = NUM_W'({r2[PERIOD_W-1:0], {PHASE_BITS{1'b0}}});
      dcwg_pkg::WAVE_TRIANGLE: num = NUM_W'({amp_k, 1'b0});
      default:                 num = NUM_W'(amp_k);
    endcase
  end

  dcwg_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (cur.period),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  // phase -> quadrant and mirrored ROM address
  always_comb begin
    quad     = quot[PHASE_BITS-1:PHASE_BITS-2];
    rom_addr = quad[0] ? (ADDR_W'(QUARTER) - ADDR_W'(quot[PHASE_BITS-3:0]))
                       : ADDR_W'(quot[PHASE_BITS-3:0]);
  end

  dcwg_sine_rom #(
    .PHASE_BITS (PHASE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (mag)
  );

  always_comb begin
    offs      = quad[1] ? (OFFS_W'(1) << MAG_W) - OFFS_W'(mag)
                        : (OFFS_W'(1) << MAG_W) + OFFS_W'(mag);
    sine_prod = PROD_W'(cur.amplitude[AMP_W-1:1]) * PROD_W'(offs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcwg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    div_start  = 1'b0;
    sample_we  = 1'b0;
    sample_val = '0;
    case (state)
      dcwg_pkg::ST_IDLE: begin
        if (tick_go) begin
          state_next = dcwg_pkg::ST_SETUP;
          ch_next    = 1'b0;
        end
      end
      dcwg_pkg::ST_SETUP: begin
        if (cur.period == '0 || cur.wave == dcwg_pkg::WAVE_SQUARE) begin
          sample_we  = 1'b1;
          sample_val = (cur.period == '0 || first_half) ? '0 : cur.amplitude;
          state_next = ch ? dcwg_pkg::ST_DONE : dcwg_pkg::ST_SETUP;
          ch_next    = 1'b1;
        end else begin
          div_start  = 1'b1;
          state_next = dcwg_pkg::ST_DIV_WAIT;
        end
      end
      dcwg_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (cur.wave == dcwg_pkg::WAVE_SINE) begin
            state_next = dcwg_pkg::ST_SCALE;
          end else begin
            sample_we  = 1'b1;
            sample_val = quot[SAMPLE_W-1:0];
            state_next = ch ? dcwg_pkg::ST_DONE : dcwg_pkg::ST_SETUP;
            ch_next    = 1'b1;
          end
        end
      end
      dcwg_pkg::ST_SCALE: begin
        sample_we  = 1'b1;
        sample_val = sine_prod[PROD_W-1:PROD_W-SAMPLE_W];
        state_next = ch ? dcwg_pkg::ST_DONE : dcwg_pkg::ST_SETUP;
        ch_next    = 1'b1;
      end
      dcwg_pkg::ST_DONE: begin
        if (result_take) begin
          state_next = dcwg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dcwg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch          <= 1'b0;
      ch_index[0] <= '0;
      ch_index[1] <= '0;
    end else begin
      ch <= ch_next;
      if (state == dcwg_pkg::ST_IDLE && tick_go) begin
        for (int c = 0; c < 2; c++) begin
          ch_index[c] <= (ch_index[c] < cfg[c].period) ? ch_index[c] + 1'b1
                                                       : PERIOD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_we) begin
      samples[ch] <= sample_val;
    end
  end

  assign busy         = (state != dcwg_pkg::ST_IDLE);
  assign result_valid = (state == dcwg_pkg::ST_DONE);
  assign sample0      = samples[0];
  assign sample1      = samples[1];

  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (state == dcwg_pkg::ST_IDLE && tick_go) |=> (state == dcwg_pkg::ST_SETUP && !ch))
    else $error("tick did not start channel 0");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_div_live: assert property (@(posedge clk) disable iff (rst)
    (state == dcwg_pkg::ST_DIV_WAIT) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == dcwg_pkg::ST_SETUP && cur.period != '0) |-> (k != '0 && k <= cur.period))
    else $error("channel index outside 1..P");

endmodule

`default_nettype wire
